// ----- sv/sampled_lfu_cache_macros.svh -----
// assertion macros shared by the sampled lfu cache rtl
`ifndef SAMPLED_LFU_CACHE_MACROS_SVH
`define SAMPLED_LFU_CACHE_MACROS_SVH

// same-cycle implication, checked outside reset
`define SLFU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SLFU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/slfu_pkg.sv -----
// shared types and constants of the sampled lfu cache
`timescale 1ns / 1ps
`default_nettype none

package slfu_pkg;

  // payload and register types
  typedef logic [31:0] word_t;
  typedef logic [4:0]  cap_t;

  // request action codes
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  // register index decoded from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  // capacity after reset
  localparam cap_t CAP_RESET = 5'd16;

endpackage

`default_nettype wire

// ----- sv/sampled_lfu_cache.sv -----
// top level of the sampled lfu key-value cache
`timescale 1ns / 1ps
`default_nettype none
`include "sampled_lfu_cache_macros.svh"

// Sampled LFU cache. Keys, valid bits and recency ranks sit in per-entry
// registers so all entries are matched in parallel. Values and use counts
// sit in one synchronous memory with one read port, one write port and a
// registered read. A get, a put on a present key and a put with free room
// hold busy through a lookup state, then a read-modify-write state, and
// start is taken only while busy is low.
// A put that must evict reads the count of each of the n = min(SAMPLE_SIZE,
// occupancy) least recent entries from the memory, in a read state and a
// compare state each, then evicts. The result is shown on the out_ ports
// for one cycle, marked by out_strobe, in the first cycle with busy low.
// It cannot be held off and the next start may be taken in that same
// cycle. No clearing pass runs after reset.
module sampled_lfu_cache #(
  parameter int ENTRIES     = 16,
  parameter int COUNT_BITS  = 16,
  parameter int SAMPLE_SIZE = 2
) (
  input  wire               clk,
  input  wire               rst_n,
  // request channel
  input  wire               start,
  output logic              busy,
  input  wire               in_action,
  input  slfu_pkg::word_t   in_key,
  input  slfu_pkg::word_t   in_value,
  // result channel
  output logic              out_strobe,
  output logic              out_hit,
  output slfu_pkg::word_t   out_read_value,
  output logic              out_evicted,
  output slfu_pkg::word_t   out_evicted_key,
  // configuration port
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire  [2:0]        paddr,
  input  slfu_pkg::word_t   pwdata,
  output slfu_pkg::word_t   prdata,
  output logic              pready
);

  import slfu_pkg::*;

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = OCC_W + 5;
  localparam int SAMP_W = $clog2(SAMPLE_SIZE + 1);
  localparam int SX_W   = SAMP_W + OCC_W;
  localparam int MEM_W  = 32 + COUNT_BITS;

  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // state codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOOK  = 3'd1;
  localparam logic [2:0] ST_UPD   = 3'd2;
  localparam logic [2:0] ST_SREAD = 3'd3;
  localparam logic [2:0] ST_SCMP  = 3'd4;
  localparam logic [2:0] ST_EVICT = 3'd5;

  logic [2:0]             state_r, state_nxt;
  cap_t                   cap_r;

  // request registers
  logic                   req_put_r;
  word_t                  req_key_r;
  word_t                  req_val_r;

  // per-entry tag state
  logic [ENTRIES-1:0]     valid_r, valid_nxt;
  word_t                  key_r   [ENTRIES];
  word_t                  key_nxt [ENTRIES];
  logic [IDX_W-1:0]       rank_r   [ENTRIES];
  logic [IDX_W-1:0]       rank_nxt [ENTRIES];
  logic [OCC_W-1:0]       occ_r, occ_nxt;

  // lookup and sampling state
  logic                   hit_r;
  logic [IDX_W-1:0]       slot_r;
  logic [SAMP_W-1:0]      samp_r;
  logic [IDX_W-1:0]       samp_lane_r;
  logic [COUNT_BITS-1:0]  best_cnt_r;

  // value and count memory
  logic [MEM_W-1:0]       mem [ENTRIES];
  logic [MEM_W-1:0]       mem_rdata_r;
  logic [IDX_W-1:0]       mem_raddr;
  logic [IDX_W-1:0]       mem_waddr;
  logic [MEM_W-1:0]       mem_wdata;
  logic                   mem_we;

  // result registers
  logic                   out_strobe_r;
  logic                   out_hit_r;
  word_t                  out_read_value_r;
  logic                   out_evicted_r;
  word_t                  out_evicted_key_r;

  // combinational helpers
  logic [ENTRIES-1:0]     match;
  logic                   any_match;
  logic [IDX_W-1:0]       match_slot;
  logic [ENTRIES-1:0]     samp_match;
  logic [IDX_W-1:0]       samp_lane;
  logic [ENTRIES-1:0]     free_vec;
  logic [IDX_W-1:0]       ins_lane;
  logic [CMP_W-1:0]       eff_cap;
  logic                   cache_full;
  logic [OCC_W-1:0]       occ_m1;
  logic [IDX_W-1:0]       gap_rank;
  word_t                  sel_key;
  word_t                  rd_val;
  logic [COUNT_BITS-1:0]  rd_cnt;
  logic [COUNT_BITS-1:0]  cnt_inc;
  logic [SAMP_W-1:0]      samp_inc;
  logic                   samp_last;
  logic                   cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_CAPACITY) ? word_t'(cap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr && (paddr[2] == REG_CAPACITY)) begin
      cap_r <= pwdata[4:0];
    end
  end

  // key match over all entries
  always_comb begin
    match_slot = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      match[i] = valid_r[i] && (key_r[i] == req_key_r);
      if (match[i]) begin
        match_slot = IDX_W'(i);
      end
    end
    any_match = |match;
  end

  // entry holding the recency rank under test
  always_comb begin
    samp_lane = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      samp_match[i] = valid_r[i] && (SX_W'(rank_r[i]) == SX_W'(samp_r));
      if (samp_match[i]) begin
        samp_lane = IDX_W'(i);
      end
    end
  end

  // first free entry, counting the victim as free while evicting
  always_comb begin
    free_vec = ~valid_r;
    if (state_r == ST_EVICT) begin
      free_vec[slot_r] = 1'b1;
    end
    ins_lane = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        ins_lane = IDX_W'(i);
      end
    end
  end

  // effective capacity and fullness
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(cap_r) > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = CMP_W'(cap_r);
    end
    cache_full = CMP_W'(occ_r) >= eff_cap;
  end

  // shared reads and arithmetic
  assign occ_m1    = occ_r - OCC_W'(1);
  assign gap_rank  = rank_r[slot_r];
  assign sel_key   = key_r[slot_r];
  assign rd_val    = mem_rdata_r[MEM_W-1 -: 32];
  assign rd_cnt    = mem_rdata_r[COUNT_BITS-1:0];
  assign cnt_inc   = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + CNT_ONE;
  assign samp_inc  = samp_r + SAMP_W'(1);
  assign samp_last = (samp_inc >= SAMP_W'(SAMPLE_SIZE)) ||
                     (SX_W'(samp_inc) >= SX_W'(occ_r));
  assign mem_raddr = (state_r == ST_LOOK) ? match_slot : samp_lane;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (req_put_r && !any_match && cache_full) begin
          state_nxt = ST_SREAD;
        end else begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD:   state_nxt = ST_IDLE;
      ST_SREAD: state_nxt = ST_SCMP;
      ST_SCMP:  state_nxt = samp_last ? ST_EVICT : ST_SREAD;
      ST_EVICT: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // entry updates and memory write
  always_comb begin
    valid_nxt = valid_r;
    occ_nxt   = occ_r;
    mem_we    = 1'b0;
    mem_waddr = slot_r;
    mem_wdata = {req_val_r, CNT_ONE};
    for (int i = 0; i < ENTRIES; i++) begin
      key_nxt[i]  = key_r[i];
      rank_nxt[i] = rank_r[i];
    end
    // close the rank gap left by a touched or evicted entry
    if ((state_r == ST_UPD && hit_r) || state_r == ST_EVICT) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_r[i] && (rank_r[i] > gap_rank)) begin
          rank_nxt[i] = rank_r[i] - IDX_W'(1);
        end
      end
    end
    unique case (state_r)
      ST_UPD: begin
        if (hit_r) begin
          rank_nxt[slot_r] = occ_m1[IDX_W-1:0];
          mem_we = 1'b1;
          if (req_put_r == ACT_GET) begin
            mem_wdata = {rd_val, cnt_inc};
          end
        end else if (req_put_r == ACT_PUT) begin
          valid_nxt[ins_lane] = 1'b1;
          key_nxt[ins_lane]   = req_key_r;
          rank_nxt[ins_lane]  = occ_r[IDX_W-1:0];
          occ_nxt   = occ_r + OCC_W'(1);
          mem_we    = 1'b1;
          mem_waddr = ins_lane;
        end
      end
      ST_EVICT: begin
        valid_nxt[slot_r]   = 1'b0;
        valid_nxt[ins_lane] = 1'b1;
        key_nxt[ins_lane]   = req_key_r;
        rank_nxt[ins_lane]  = occ_m1[IDX_W-1:0];
        mem_we    = 1'b1;
        mem_waddr = ins_lane;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
    end
  end

  // tag payload registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      key_r[i]  <= key_nxt[i];
      rank_r[i] <= rank_nxt[i];
    end
  end

  // request capture, lookup result and victim sampling
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      req_put_r <= in_action;
      req_key_r <= in_key;
      req_val_r <= in_value;
    end
    if (state_r == ST_LOOK) begin
      hit_r  <= any_match;
      slot_r <= match_slot;
      samp_r <= '0;
    end
    if (state_r == ST_SREAD) begin
      samp_lane_r <= samp_lane;
    end
    if (state_r == ST_SCMP) begin
      samp_r <= samp_inc;
      if (samp_r == '0 || rd_cnt < best_cnt_r) begin
        slot_r     <= samp_lane_r;
        best_cnt_r <= rd_cnt;
      end
    end
  end

  // value and count memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (state_r == ST_UPD) || (state_r == ST_EVICT);
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state_r == ST_UPD) begin
      out_hit_r         <= hit_r;
      out_read_value_r  <= (hit_r && req_put_r == ACT_GET) ? rd_val : '0;
      out_evicted_r     <= 1'b0;
      out_evicted_key_r <= '0;
    end else if (state_r == ST_EVICT) begin
      out_hit_r         <= 1'b0;
      out_read_value_r  <= '0;
      out_evicted_r     <= 1'b1;
      out_evicted_key_r <= sel_key;
    end
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_strobe      = out_strobe_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_read_value_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evicted_key_r;

  // checks
  `SLFU_ASSERT_IMP(a_occ_count, clk, rst_n, 1'b1, $countones(valid_r) == int'(occ_r), "occupancy differs from valid entries")
  `SLFU_ASSERT_IMP(a_key_unique, clk, rst_n, state_r == ST_LOOK, $onehot0(match), "key present in more than one entry")
  `SLFU_ASSERT_IMP(a_strobe_src, clk, rst_n, out_strobe_r, $past(state_r) == ST_UPD || $past(state_r) == ST_EVICT, "result strobe without update")
  `SLFU_ASSERT_IMP(a_evict_miss, clk, rst_n, out_strobe_r && out_evicted_r, !out_hit_r, "eviction reported on a hit")
  `SLFU_ASSERT_NEXT(a_evict_occ, clk, rst_n, state_r == ST_EVICT, occ_r == $past(occ_r), "eviction changed occupancy")

endmodule

`default_nettype wire
